// ----- hdl/dsc_pkg.sv -----
// shared constants and codes for the dmx slot capture switch
package dsc_pkg;

    localparam int SLOT_W   = 10;
    localparam int LEVEL_W  = 8;
    localparam int TIMER_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_BITS = 8;

    localparam logic [SLOT_W-1:0]  RESET_START_ADDRESS = 10'd1;
    localparam logic [LEVEL_W-1:0] RESET_THRESHOLD     = 8'd127;
    localparam logic [TIMER_W-1:0] RESET_TIMEOUT       = 16'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ADDRESS = 2'd0,
        CFG_ON_THRESHOLD  = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } cfg_idx_t;

    // input item kind carried in tuser bit 0
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

// ----- hdl/dmx_slot_capture_switch.sv -----
// dmx512 slot capture switch: break/start code tracking, slot capture, thresholds, loss timer
// path: each item goes through the input register and then the result register
// throughput: one item per cycle unless a pending result waits on m_axis_tready;
// the state update and the level compares sit between the input register and
// the result register, with no iteration
// reset: rst_n async active low clears slot count, channels and flags, loads the loss
// timer with 20000 and the registers with start 1, threshold 127, timeout 20000
module dmx_slot_capture_switch #(
    parameter int CHANNEL_COUNT = 8,
    parameter int SLOT_LIMIT    = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [dsc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    input  logic [2:0]                    s_axis_tuser,   // [0] operation, [1] framing_error,
                                                          // [2] overrun_error
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] switch_outputs
    output logic [0:0]                    m_axis_tuser    // [0] signal_lost
);
    import dsc_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(SLOT_LIMIT);

    // configuration
    logic [SLOT_W-1:0]  start_address_reg;
    logic [LEVEL_W-1:0] on_threshold_reg;
    logic [TIMER_W-1:0] timeout_ticks_reg;

    // input register
    logic               in_valid_reg;
    logic               op_reg;
    logic [7:0]         byte_reg;
    logic               ferr_reg;
    logic               oerr_reg;

    // block state
    logic [SLOT_W-1:0]  slot_index_reg, slot_index_next;
    logic [LEVEL_W-1:0] level_reg  [CHANNEL_COUNT];
    logic [LEVEL_W-1:0] level_next [CHANNEL_COUNT];
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               ignored_reg, ignored_next;

    // result register
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_bits_reg, out_bits_next;
    logic                out_lost_reg;

    logic               advance;
    logic [SLOT_W-1:0]  first_slot;
    logic [SLOT_W-1:0]  offset;
    logic               in_window;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= RESET_START_ADDRESS;
            on_threshold_reg  <= RESET_THRESHOLD;
            timeout_ticks_reg <= RESET_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_START_ADDRESS: start_address_reg <= cfg_data[SLOT_W-1:0];
                CFG_ON_THRESHOLD:  on_threshold_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TIMER_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg   <= s_axis_tuser[0];
            ferr_reg <= s_axis_tuser[1];
            oerr_reg <= s_axis_tuser[2];
            byte_reg <= s_axis_tdata;
        end
    end

    // zero start address behaves as slot one
    assign first_slot = (start_address_reg == '0) ? SLOT_W'(1) : start_address_reg;
    assign offset     = slot_index_reg - first_slot;
    assign in_window  = (slot_index_reg <= SLOT_MAX) && (slot_index_reg >= first_slot);

    always_comb
    begin
        slot_index_next = slot_index_reg;
        timer_next      = timer_reg;
        ignored_next    = ignored_reg;
        for (int k = 0; k < CHANNEL_COUNT; k++)
            level_next[k] = level_reg[k];

        if (op_reg == OP_TICK)
        begin
            if (timer_reg != '0)
                timer_next = timer_reg - TIMER_W'(1);
            if (timer_next == '0)
                for (int k = 0; k < CHANNEL_COUNT; k++)
                    level_next[k] = '0;
        end
        else if (ferr_reg || oerr_reg)
        begin
            // break: start looking for a new start code
            slot_index_next = '0;
            ignored_next    = 1'b0;
        end
        else if (!ignored_reg)
        begin
            if (slot_index_reg == '0)
            begin
                if (byte_reg == 8'd0)
                begin
                    slot_index_next = SLOT_W'(1);
                    timer_next      = timeout_ticks_reg;
                end
                else
                    ignored_next = 1'b1;
            end
            else
            begin
                for (int k = 0; k < CHANNEL_COUNT; k++)
                    if (in_window && offset == SLOT_W'(k))
                        level_next[k] = byte_reg;
                // count stops one past the last slot
                if (slot_index_reg <= SLOT_MAX)
                    slot_index_next = slot_index_reg + SLOT_W'(1);
            end
        end
    end

    for (genvar g = 0; g < OUT_BITS; g++)
    begin : g_out
        if (g < CHANNEL_COUNT)
        begin : g_on
            assign out_bits_next[g] = (level_next[g] >= on_threshold_reg);
        end
        else
        begin : g_off
            assign out_bits_next[g] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg <= '0;
            timer_reg      <= RESET_TIMEOUT;
            ignored_reg    <= 1'b0;
            for (int k = 0; k < CHANNEL_COUNT; k++)
                level_reg[k] <= '0;
        end
        else if (advance)
        begin
            slot_index_reg <= slot_index_next;
            timer_reg      <= timer_next;
            ignored_reg    <= ignored_next;
            for (int k = 0; k < CHANNEL_COUNT; k++)
                level_reg[k] <= level_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bits_reg <= out_bits_next;
            out_lost_reg <= (timer_next == '0);
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_bits_reg;
    assign m_axis_tuser[0] = out_lost_reg;

    // an ignored frame only exists before any slot has been counted
    a_ignored_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ignored_reg |-> (slot_index_reg == '0))
        else $error("frame ignored with non-zero slot count");

    a_slot_sat: assert property (@(posedge clk) disable iff (!rst_n)
        slot_index_reg <= SLOT_MAX + SLOT_W'(1))
        else $error("slot count beyond saturation");

    // the reported loss flag follows the timer left by the item
    a_lost_flag: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (m_axis_tuser[0] == (timer_reg == '0)))
        else $error("signal_lost does not match loss timer");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while input register is empty");

endmodule
